FILE: design/spt_pkg.sv
// ---------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the stereo point triangulation unit.
// ---------------------------------------------------------------------------
package spt_pkg;

  localparam int PIX_W      = 16;              // Q12.4 pixel coordinate
  localparam int WORD_W     = 32;              // config and result words
  localparam int FRAC_SHIFT = 4;               // Q12.4 -> integer scaling of the dividend
  localparam int DIVIDEND_W = WORD_W + FRAC_SHIFT;
  localparam int DIVISOR_W  = PIX_W;
  localparam int DIV_STEPS  = DIVIDEND_W;      // one quotient bit per stage
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE_FOCAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_FOCAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_U    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_V    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISPARITY  = 3'd4;

  localparam logic [PIX_W-1:0] MIN_DISPARITY_RESET = 16'd32;

  // Side data carried alongside the division
  typedef struct packed {
    logic             acc;     // disparity reached the minimum
    logic             neg_u;
    logic [PIX_W-1:0] mag_u;   // |left_u - principal_u|
    logic             neg_v;
    logic [PIX_W-1:0] mag_v;   // |left_v - principal_v|
  } spt_tag_t;

endpackage

FILE: design/spt_divider.sv
// ---------------------------------------------------------------------------
// spt_divider
// Pipelined restoring divider, one quotient bit per register stage, with a
// side-data tag travelling alongside each item.
// ---------------------------------------------------------------------------
module spt_divider import spt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  input  spt_tag_t              in_tag,
  output logic                  quo_valid,
  output logic [DIVIDEND_W-1:0] quotient,
  output spt_tag_t              quo_tag
);

  localparam int W = DIVISOR_W + DIVIDEND_W;

  // work word: {partial remainder, remaining dividend bits / quotient bits}
  logic                 stg_valid [DIV_STEPS];
  logic [W-1:0]         stg_work  [DIV_STEPS];
  logic [DIVISOR_W-1:0] stg_div   [DIV_STEPS];
  spt_tag_t             stg_tag   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                 v_in;
    logic [W-1:0]         work_in;
    logic [DIVISOR_W-1:0] d_in;
    spt_tag_t             tag_in;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 take;
    logic [W-1:0]         work_next;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign work_in = {{DIVISOR_W{1'b0}}, dividend};
      assign d_in    = divisor;
      assign tag_in  = in_tag;
    end else begin : g_rest
      assign v_in    = stg_valid[k-1];
      assign work_in = stg_work[k-1];
      assign d_in    = stg_div[k-1];
      assign tag_in  = stg_tag[k-1];
    end

    // a set top bit of the trial always exceeds the divisor, so it is never lost
    assign trial     = work_in[W-1:DIVIDEND_W-1];
    assign diff      = trial - {1'b0, d_in};
    assign take      = trial >= {1'b0, d_in};
    assign work_next = {take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0],
                        work_in[DIVIDEND_W-2:0], take};

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[k] <= 1'b0;
      end else if (en) begin
        stg_valid[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_work[k] <= work_next;
        stg_div[k]  <= d_in;
        stg_tag[k]  <= tag_in;
      end
    end
  end

  assign quo_valid = stg_valid[DIV_STEPS-1];
  assign quotient  = stg_work[DIV_STEPS-1][DIVIDEND_W-1:0];
  assign quo_tag   = stg_tag[DIV_STEPS-1];

endmodule

FILE: design/stereo_point_triangulation_unit.sv
// ---------------------------------------------------------------------------
// stereo_point_triangulation_unit
// Rectified stereo triangulation: disparity, depth by division, then lateral
// and vertical coordinates scaled by inverse focal length, saturated.
// ---------------------------------------------------------------------------
// Pipeline: front stage loaded at the accept edge, then 36 divider stages,
// 2 multiply stages, output register. Throughput: one item per cycle
// while in_stall is low; the bit-per-stage divider pipeline sets the depth.
// A two-entry output register and skid buffer absorb a stall.
// Reset (rst, synchronous): empties the pipeline and loads the register
// defaults (min_disparity two pixels, all others zero).
module stereo_point_triangulation_unit import spt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     left_u,
  input  logic [PIX_W-1:0]     left_v,
  input  logic [PIX_W-1:0]     right_u,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 point_valid,
  output logic signed [WORD_W-1:0] point_x,
  output logic signed [WORD_W-1:0] point_y,
  output logic [WORD_W-1:0]    point_z
);

  localparam int PROD_W = PIX_W + WORD_W;   // 16 x 32 partial product

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } spt_result_t;

  // Scaled magnitude -> signed word, truncated toward zero and saturated
  function automatic logic [WORD_W-1:0] scale_sat(input logic [PROD_W-1:0] pa,
                                                   input logic [PROD_W-1:0] pb,
                                                   input logic neg);
    logic [PROD_W-1:0]   sum;
    logic [PROD_W-3:0]   r;
    logic                big;
    logic [WORD_W-1:0]   res;
    sum = pa + {{WORD_W{1'b0}}, pb[PROD_W-1:WORD_W]};
    r   = sum[PROD_W-1:2];
    big = |r[PROD_W-3:WORD_W-1];
    if (neg) begin
      res = big ? {1'b1, {(WORD_W-1){1'b0}}} : (~r[WORD_W-1:0] + 1'b1);
    end else begin
      res = big ? {1'b0, {(WORD_W-1){1'b1}}} : r[WORD_W-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [WORD_W-1:0] baseline_focal;
  logic [WORD_W-1:0] inverse_focal;
  logic [PIX_W-1:0]  principal_u;
  logic [PIX_W-1:0]  principal_v;
  logic [PIX_W-1:0]  min_disparity;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_focal <= '0;
      inverse_focal  <= '0;
      principal_u    <= '0;
      principal_v    <= '0;
      min_disparity  <= MIN_DISPARITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASELINE_FOCAL: baseline_focal <= cfg_data;
        REG_INVERSE_FOCAL:  inverse_focal  <= cfg_data;
        REG_PRINCIPAL_U:    principal_u    <= cfg_data[PIX_W-1:0];
        REG_PRINCIPAL_V:    principal_v    <= cfg_data[PIX_W-1:0];
        REG_MIN_DISPARITY:  min_disparity  <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the skid buffer is holding an item
  logic en;
  logic skid_full;
  assign en       = !skid_full;
  assign in_stall = skid_full;

  // front stage: disparity, acceptance, centred offsets
  logic [PIX_W:0] disp;
  logic [PIX_W:0] off_u;
  logic [PIX_W:0] off_v;
  logic [PIX_W:0] neg_off_u;
  logic [PIX_W:0] neg_off_v;
  spt_tag_t       tag_next;

  assign disp      = {1'b0, left_u} - {1'b0, right_u};
  assign off_u     = {1'b0, left_u} - {1'b0, principal_u};
  assign off_v     = {1'b0, left_v} - {1'b0, principal_v};
  assign neg_off_u = ~off_u + 1'b1;
  assign neg_off_v = ~off_v + 1'b1;

  always_comb begin
    tag_next.acc   = !disp[PIX_W] && (disp[PIX_W-1:0] >= min_disparity);
    tag_next.neg_u = off_u[PIX_W];
    tag_next.mag_u = off_u[PIX_W] ? neg_off_u[PIX_W-1:0] : off_u[PIX_W-1:0];
    tag_next.neg_v = off_v[PIX_W];
    tag_next.mag_v = off_v[PIX_W] ? neg_off_v[PIX_W-1:0] : off_v[PIX_W-1:0];
  end

  logic             a_valid;
  logic [PIX_W-1:0] a_disp;
  spt_tag_t         a_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_disp <= disp[PIX_W-1:0];
      a_tag  <= tag_next;
    end
  end

  // depth: (baseline_focal << 4) / disparity; a zero divisor yields all ones
  logic                  q_valid;
  logic [DIVIDEND_W-1:0] q_quo;
  spt_tag_t              q_tag;

  spt_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .dividend  ({baseline_focal, {FRAC_SHIFT{1'b0}}}),
    .divisor   (a_disp),
    .in_tag    (a_tag),
    .quo_valid (q_valid),
    .quotient  (q_quo),
    .quo_tag   (q_tag)
  );

  logic [WORD_W-1:0] z_sat;
  assign z_sat = (|q_quo[DIVIDEND_W-1:WORD_W]) ? {WORD_W{1'b1}} : q_quo[WORD_W-1:0];

  // multiply stage 1: t = inverse_focal * z
  logic                m1_valid;
  logic [2*WORD_W-1:0] m1_t;
  logic [WORD_W-1:0]   m1_z;
  spt_tag_t            m1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_t   <= inverse_focal * z_sat;
      m1_z   <= z_sat;
      m1_tag <= q_tag;
    end
  end

  // multiply stage 2: offset magnitude times each half of t
  logic              m2_valid;
  logic [PROD_W-1:0] m2_pa_u;
  logic [PROD_W-1:0] m2_pb_u;
  logic [PROD_W-1:0] m2_pa_v;
  logic [PROD_W-1:0] m2_pb_v;
  logic [WORD_W-1:0] m2_z;
  spt_tag_t          m2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_pa_u <= m1_tag.mag_u * m1_t[2*WORD_W-1:WORD_W];
      m2_pb_u <= m1_tag.mag_u * m1_t[WORD_W-1:0];
      m2_pa_v <= m1_tag.mag_v * m1_t[2*WORD_W-1:WORD_W];
      m2_pb_v <= m1_tag.mag_v * m1_t[WORD_W-1:0];
      m2_z    <= m1_z;
      m2_tag  <= m1_tag;
    end
  end

  // final stage: combine, scale by 2^-34, saturate; rejected items read zero
  spt_result_t head;

  always_comb begin
    head.valid = m2_tag.acc;
    head.x     = '0;
    head.y     = '0;
    head.z     = '0;
    if (m2_tag.acc) begin
      head.x = scale_sat(m2_pa_u, m2_pb_u, m2_tag.neg_u);
      head.y = scale_sat(m2_pa_v, m2_pb_v, m2_tag.neg_v);
      head.z = m2_z;
    end
  end

  // output register with one skid entry
  spt_result_t out_res;
  spt_result_t skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (out_valid && out_stall) begin
      if (m2_valid) begin
        skid_full <= 1'b1;
      end
    end else begin
      out_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!out_stall) begin
        out_res <= skid_res;
      end
    end else if (out_valid && out_stall) begin
      if (m2_valid) begin
        skid_res <= head;
      end
    end else begin
      out_res <= head;
    end
  end

  assign point_valid = out_res.valid;
  assign point_x     = out_res.x;
  assign point_y     = out_res.y;
  assign point_z     = out_res.z;

endmodule
